// ===== rtl/dms_pkg.sv =====
// Shared constants, codes and types of the degenerate motif search block.
// No dependencies; every other file of the block but dms_ram imports it.
`timescale 1ns / 1ps

package dms_pkg;

  localparam int MAX_PATTERN_DEF  = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int COUNT_W = 32;
  localparam int ERR_W   = 6;
  localparam int LEN_W   = 6;
  localparam int PIDX_W  = 5;
  localparam int SYM_W   = 8;
  localparam int POS_W   = 33;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;

  localparam logic [ERR_W-1:0]   ERR_MAX   = '1;
  localparam logic [COUNT_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0]   NO_MATCH  = '1;
  localparam logic [POS_W-1:0]   POS_BIAS  = 33'd2;

  localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_ERRORS     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_START_POSITION = 2'd2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_STREAM = 1'b1;

  typedef struct packed {
    logic shift;
    logic proc;
    logic first;
    logic tail;
    logic sym_ok;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic                    found;
    logic signed [POS_W-1:0] match_position;
    logic [ERR_W-1:0]        errors_found;
  } result_t;

endpackage

// ===== rtl/dms_if.sv =====
// Handshake channels of the motif search block: item input and result output.
// Depends on dms_pkg for field widths.
`timescale 1ns / 1ps

interface dms_item_if import dms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [PIDX_W-1:0] pattern_index;
  logic [SYM_W-1:0]  symbol;
  logic              accept;
  logic              last;

  modport source (output valid, func, pattern_index, symbol, accept, last, input ready);
  modport sink (input valid, func, pattern_index, symbol, accept, last, output ready);
endinterface

interface dms_result_if import dms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [POS_W-1:0] match_position;
  logic [ERR_W-1:0]        errors_found;

  modport source (output valid, found, match_position, errors_found, input ready);
  modport sink (input valid, found, match_position, errors_found, output ready);
endinterface

// ===== rtl/dms_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dms_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/dms_cell.sv =====
// One pattern position: its accept column and one window mismatch counter of the ring.
// Depends on dms_pkg and dms_ram.
`timescale 1ns / 1ps

module dms_cell import dms_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cell_ctl_t                       ctl,
  input  logic [ERR_W-1:0]                max_errors,
  input  logic                            mem_we,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] mem_addr,
  input  logic                            mem_wdata,
  input  logic [ERR_W-1:0]                cnt_in,
  output logic [ERR_W-1:0]                cnt_out,
  output logic                            hit,
  output logic [ERR_W-1:0]                hit_errors
);

  logic             accept_bit;
  logic [ERR_W-1:0] cnt;
  logic [ERR_W-1:0] cnt_next;
  logic [ERR_W-1:0] base;
  logic [ERR_W-1:0] upd;
  logic             mismatch;

  dms_ram #(
    .WIDTH(1),
    .DEPTH(SYMBOL_COUNT)
  ) u_col (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(accept_bit)
  );

  always_comb begin
    base     = ctl.first ? '0 : cnt_in;
    mismatch = !(ctl.sym_ok && accept_bit);
    upd      = (mismatch && (base != ERR_MAX)) ? base + ERR_W'(1) : base;
    cnt_next = ctl.proc ? upd : cnt_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.shift) begin
      cnt <= cnt_next;
    end
  end

  assign cnt_out    = cnt;
  assign hit        = ctl.proc && ctl.tail && (upd <= max_errors);
  assign hit_errors = upd;

endmodule

// ===== rtl/dms_out_buf.sv =====
// Four-entry result queue between the cell row and the result channel.
// Depends on dms_pkg.
`timescale 1ns / 1ps

module dms_out_buf import dms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  input  logic       pop,
  output logic       not_empty,
  output result_t    head,
  output logic [2:0] fill
);

  result_t    slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       do_pop;

  assign not_empty = (fill != 3'd0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + 3'(push) - 3'(do_pop);
    end
  end

endmodule

// ===== rtl/degenerate_motif_search.sv =====
// Top level of the degenerate motif search: config registers, clearing pass, cell ring.
// Depends on dms_pkg, dms_if, dms_cell and dms_out_buf.
//
//   channel   kind          contents
//   items     valid/ready   func, pattern_index, symbol, accept, last
//   results   valid/ready   found, match_position, errors_found
//   cfg       write only    cfg_we, cfg_index, cfg_data
//
// One item per cycle. A symbol is read from the accept columns in the cycle of its
// transfer and scored by the cell ring in the next; any result it yields enters the
// output queue at the edge after its transfer. After reset a clearing pass over all
// SYMBOL_COUNT addresses zeroes the accept table, with items held off. Items are held
// off while the output queue could not absorb the result of the symbol in flight.
`timescale 1ns / 1ps

module degenerate_motif_search import dms_pkg::*; #(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dms_item_if.sink          items,
  dms_result_if.source      results,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]   pattern_length;
  logic [ERR_W-1:0]   max_errors;
  logic [COUNT_W-1:0] start_position;

  logic [COUNT_W-1:0] symbol_count;
  logic [COUNT_W-1:0] symbol_count_next;
  logic               search_done;
  logic               search_done_next;

  logic               clearing;
  logic [AW-1:0]      clr_addr;

  logic               s1_valid;
  logic               s1_sym_ok;
  logic               s1_last;

  logic               take;
  logic               take_load;
  logic               sym_in_range;
  logic [AW-1:0]      mem_addr;
  logic               mem_wdata;

  logic [LW-1:0]      len_eff;
  logic [COUNT_W-1:0] start_eff;
  logic [COUNT_W+1:0] reach;
  logic [LW-1:0]      reach_clamp;
  logic               reach_neg;
  logic               saturated;
  logic               do_sym;

  logic [ERR_W-1:0]   cnt_q [MAX_PATTERN];
  logic [ERR_W-1:0]   hit_err [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_vec;
  logic               hit_any;
  logic [ERR_W-1:0]   err_sel;
  logic [POS_W-1:0]   match_pos;

  logic               push;
  result_t            push_data;
  result_t            head;
  logic [2:0]         fill;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      max_errors     <= '0;
      start_position <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_MAX_ERRORS:     max_errors     <= cfg_data[ERR_W-1:0];
        REG_START_POSITION: start_position <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the accept table
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(SYMBOL_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign items.ready  = !clearing && ((fill + 3'(s1_valid)) < 3'd4);
  assign take         = items.valid && items.ready;
  assign sym_in_range = {1'b0, items.symbol} < 9'(SYMBOL_COUNT);
  assign take_load    = take && (items.func == FUNC_LOAD) && sym_in_range;
  assign mem_addr     = clearing ? clr_addr : items.symbol[AW-1:0];
  assign mem_wdata    = clearing ? 1'b0 : items.accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take && (items.func == FUNC_STREAM);
    end
  end

  always_ff @(posedge clk) begin
    s1_sym_ok <= sym_in_range;
    s1_last   <= items.last;
  end

  // effective settings and window reach of the symbol being scored
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LW'(1);
    end else if ({1'b0, pattern_length} > 7'(MAX_PATTERN)) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(pattern_length);
    end
    start_eff = (start_position == '0) ? COUNT_W'(1) : start_position;
    reach     = (COUNT_W+2)'(symbol_count) + (COUNT_W+2)'(1) - (COUNT_W+2)'(start_eff);
    reach_neg = reach[COUNT_W+1];
    if (reach >= (COUNT_W+2)'(MAX_PATTERN)) begin
      reach_clamp = LW'(MAX_PATTERN);
    end else begin
      reach_clamp = LW'(reach);
    end
    saturated = (symbol_count == POS_MAX);
    do_sym    = s1_valid && !saturated;
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    cell_ctl_t ctl;
    logic      we;

    assign we = clearing ||
                (take_load && ({{(32-PIDX_W){1'b0}}, items.pattern_index} == 32'(j)));

    always_comb begin
      ctl.shift  = do_sym;
      ctl.proc   = do_sym && !search_done && !reach_neg &&
                   (reach_clamp >= LW'(j)) && (LW'(j) < len_eff);
      ctl.first  = (j == 0);
      ctl.tail   = (LW'(j + 1) == len_eff);
      ctl.sym_ok = s1_sym_ok;
      ctl.clear  = s1_valid && s1_last;
    end

    dms_cell #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .max_errors(max_errors),
      .mem_we    (we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .cnt_in    (cnt_q[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
      .cnt_out   (cnt_q[j]),
      .hit       (hit_vec[j]),
      .hit_errors(hit_err[j])
    );
  end

  always_comb begin
    err_sel = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      err_sel = err_sel | (hit_vec[j] ? hit_err[j] : '0);
    end
    hit_any   = |hit_vec;
    match_pos = POS_W'(symbol_count) + POS_BIAS - POS_W'(len_eff);
  end

  // sequence state
  always_comb begin
    symbol_count_next = symbol_count;
    search_done_next  = search_done;
    if (s1_valid) begin
      if (s1_last) begin
        symbol_count_next = '0;
        search_done_next  = 1'b0;
      end else begin
        if (do_sym) begin
          symbol_count_next = symbol_count + COUNT_W'(1);
        end
        if (hit_any) begin
          search_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      search_done  <= 1'b0;
    end else begin
      symbol_count <= symbol_count_next;
      search_done  <= search_done_next;
    end
  end

  always_comb begin
    push = s1_valid && (hit_any || (s1_last && !search_done));
    if (hit_any) begin
      push_data.found          = 1'b1;
      push_data.match_position = match_pos;
      push_data.errors_found   = err_sel;
    end else begin
      push_data.found          = 1'b0;
      push_data.match_position = NO_MATCH;
      push_data.errors_found   = '0;
    end
  end

  dms_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (results.ready),
    .not_empty(results.valid),
    .head     (head),
    .fill     (fill)
  );

  assign results.found          = head.found;
  assign results.match_position = head.match_position;
  assign results.errors_found   = head.errors_found;

endmodule
